// ===== sv/dsr_pkg.sv =====
// Shared types, constants and codes for the data stack with rotate.
`default_nettype none

package dsr_pkg;

  // Stack geometry.
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MIN_SWAP    = 2;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam logic        REG_CAPACITY = 1'b0;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(64);

  // Operation codes of a request.
  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_DUP    = 3'd2,
    OP_SWAP   = 3'd3,
    OP_ROLL   = 3'd4,
    OP_REWIND = 3'd5,
    OP_CALL   = 3'd6
  } op_e;

  // Status codes of a result.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_FEW    = 2'd2,
    ST_NOCALL = 2'd3
  } status_e;

  // Movement broadcast to the row of cells.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_DUP,
    CMD_POP,
    CMD_SWAP,
    CMD_ROLL,
    CMD_REWIND
  } cmd_e;

  // Where a cell takes its next word from.
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_TOP,
    SEL_PICK
  } sel_e;

  typedef struct packed {
    cmd_e             kind;
    logic [CNT_W-1:0] n;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [WORD_W-1:0] push_value;
    logic [CNT_W-1:0]         rotate_count;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] top_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         fill_level;
  } out_rsp_t;

endpackage

`default_nettype wire

// ===== sv/dsr_cell.sv =====
// One stack cell: holds the word at a fixed depth below the top.
`default_nettype none

module dsr_cell
  import dsr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire cell_cmd_t         cmd_i,
  input  wire logic [WORD_W-1:0] left_i,
  input  wire logic [WORD_W-1:0] right_i,
  input  wire logic [WORD_W-1:0] top_i,
  input  wire logic [WORD_W-1:0] pick_i,
  output logic      [WORD_W-1:0] word_o
);

  logic [WORD_W-1:0] word_q, word_d;
  logic [CNT_W-1:0]  idx;
  logic              is_top, is_second, below_n, at_n_last;
  sel_e              sel;

  assign idx       = CNT_W'(idx_i);
  assign is_top    = (idx == '0);
  assign is_second = (idx == CNT_W'(1));
  assign below_n   = (idx < cmd_i.n);
  assign at_n_last = (idx == (cmd_i.n - CNT_W'(1)));

  // Decode the broadcast movement into this cell's source.
  always_comb begin
    sel = SEL_HOLD;
    unique case (cmd_i.kind)
      CMD_PUSH:   sel = SEL_LEFT;
      CMD_DUP:    sel = is_top ? SEL_HOLD : SEL_LEFT;
      CMD_POP:    sel = SEL_RIGHT;
      CMD_SWAP: begin
        if (is_top) begin
          sel = SEL_RIGHT;
        end else if (is_second) begin
          sel = SEL_LEFT;
        end
      end
      CMD_ROLL: begin
        if (is_top) begin
          sel = SEL_PICK;
        end else if (below_n) begin
          sel = SEL_LEFT;
        end
      end
      CMD_REWIND: begin
        if (at_n_last) begin
          sel = SEL_TOP;
        end else if (below_n) begin
          sel = SEL_RIGHT;
        end
      end
      default:    sel = SEL_HOLD;
    endcase
  end

  // Select the next word.
  always_comb begin
    case (sel)
      SEL_LEFT:  word_d = left_i;
      SEL_RIGHT: word_d = right_i;
      SEL_TOP:   word_d = top_i;
      SEL_PICK:  word_d = pick_i;
      default:   word_d = word_q;
    endcase
  end

  // Stored word, no reset needed.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

// ===== sv/dsr_ctrl.sv =====
// Request decoder: checks limits, picks the cell movement and forms the result.
`default_nettype none

module dsr_ctrl
  import dsr_pkg::*;
(
  input  wire in_req_t           req_i,
  input  wire logic              fire_i,
  input  wire logic [CNT_W-1:0]  count_i,
  input  wire logic [CNT_W-1:0]  capacity_i,
  input  wire logic [WORD_W-1:0] top_word_i,
  output cell_cmd_t              cmd_o,
  output out_rsp_t               rsp_o,
  output logic [CNT_W-1:0]       count_o
);

  logic [CNT_W-1:0] eff_cap;
  logic             is_full, is_empty;
  logic [CNT_W-1:0] n;
  cmd_e             kind;
  status_e          status;
  logic [WORD_W-1:0] removed;
  logic [CNT_W-1:0] count_d;

  // Capacity is bounded by the physical depth.
  assign eff_cap  = (capacity_i > CNT_W'(STACK_DEPTH)) ? CNT_W'(STACK_DEPTH) : capacity_i;
  assign is_full  = (count_i >= eff_cap);
  assign is_empty = (count_i == '0);
  assign n        = req_i.rotate_count;

  // Decide the operation outcome.
  always_comb begin
    kind    = CMD_NONE;
    status  = ST_OK;
    removed = '0;
    count_d = count_i;
    case (req_i.operation)
      OP_PUSH: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          kind    = CMD_PUSH;
          count_d = count_i + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (is_empty) begin
          status = ST_FEW;
        end else begin
          kind    = CMD_POP;
          removed = top_word_i;
          count_d = count_i - CNT_W'(1);
        end
      end
      OP_DUP: begin
        if (is_empty) begin
          status = ST_FEW;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          kind    = CMD_DUP;
          count_d = count_i + CNT_W'(1);
        end
      end
      OP_SWAP: begin
        if (count_i < CNT_W'(MIN_SWAP)) begin
          status = ST_FEW;
        end else begin
          kind = CMD_SWAP;
        end
      end
      OP_ROLL, OP_REWIND: begin
        if (count_i < n) begin
          status = ST_FEW;
        end else if (n >= CNT_W'(2)) begin
          kind = (req_i.operation == OP_ROLL) ? CMD_ROLL : CMD_REWIND;
        end
      end
      OP_CALL: begin
        if (is_empty) begin
          status = ST_FEW;
        end else if (!top_word_i[WORD_W-1]) begin
          status = ST_NOCALL;
        end else begin
          kind    = CMD_POP;
          removed = top_word_i;
          count_d = count_i - CNT_W'(1);
        end
      end
      default: begin
        kind = CMD_NONE;
      end
    endcase
  end

  // Cells move only on an accepted request.
  assign cmd_o.kind = fire_i ? kind : CMD_NONE;
  assign cmd_o.n    = n;

  assign rsp_o.top_value  = removed;
  assign rsp_o.status     = status;
  assign rsp_o.fill_level = count_d;
  assign count_o          = count_d;

endmodule

`default_nettype wire

// ===== sv/data_stack_with_rotate_top.sv =====
// Top level of the data stack with rotate: cell row, decoder, registers and APB port.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i / in_ready_o  in_req_i  (operation, push_value, rotate_count)
//   out       output     out_valid_o / out_ready_i out_rsp_o (top_value, status, fill_level)
//   config    input      APB psel/penable/pready  paddr, pwdata, prdata (capacity_limit)
//
// Each request's result is registered and shows the cycle after the request is taken.
// A new request is taken while the previous result is being taken by the consumer.
// Roll and rewind move all affected cells in parallel.
// Reset clears the fill count, the output valid and sets the capacity to 64.
// A stalled result blocks only new requests; the stack state is untouched meanwhile.
`default_nettype none

module data_stack_with_rotate_top
  import dsr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_req_t               in_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_rsp_t                   out_rsp_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  capacity_q;
  logic              out_valid_q;
  out_rsp_t          out_rsp_q, rsp;
  logic              fire;
  logic              cfg_write;
  cell_cmd_t         cmd;
  logic [WORD_W-1:0] words [STACK_DEPTH];
  logic [WORD_W-1:0] pick_word;
  logic [CNT_W-1:0]  pick_pos;

  // Request handshake.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[CFG_ADDR_W-1:2] == REG_CAPACITY);
  assign prdata    = (paddr[CFG_ADDR_W-1:2] == REG_CAPACITY)
                     ? CFG_DATA_W'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity_q <= pwdata[CNT_W-1:0];
    end
  end

  // Request decoder.
  dsr_ctrl u_ctrl (
    .req_i      (in_req_i),
    .fire_i     (fire),
    .count_i    (count_q),
    .capacity_i (capacity_q),
    .top_word_i (words[0]),
    .cmd_o      (cmd),
    .rsp_o      (rsp),
    .count_o    (count_d)
  );

  // Entry picked up by roll: n-1 places below the top.
  assign pick_pos  = cmd.n - CNT_W'(1);
  assign pick_word = words[pick_pos[IDX_W-1:0]];

  // Row of cells; cell 0 is the top and takes the pushed word from its left.
  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = in_req_i.push_value;
    end else begin : g_mid
      assign left_w = words[k-1];
    end
    if (k == STACK_DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = words[k+1];
    end
    dsr_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(k)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .top_i   (words[0]),
      .pick_i  (pick_word),
      .word_o  (words[k])
    );
  end

  // Fill count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // The fill count never passes the physical depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("fill count above stack depth");

  // A pending result reports the current fill count.
  a_fill_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.fill_level == count_q))
    else $error("result fill level differs from fill count");

  // A failed request returns a zero word; only a successful pop or call returns the removed word.
  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status != ST_OK)) |-> (out_rsp_o.top_value == '0))
    else $error("failed request returned a word");

  // A failed request leaves the fill count unchanged.
  a_fail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (rsp.status != ST_OK)) |=> (count_q == $past(count_q)))
    else $error("failed request changed the fill count");

endmodule

`default_nettype wire
